// ===== rtl/median_filter_3x3_assert.svh =====
// Assertion macros for the 3x3 median filter checker.
// Each macro expands to one labeled concurrent assertion on a rising clock edge,
// disabled while the asynchronous reset is asserted.
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MF3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MF3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mf3_pkg.sv =====
// Shared types, constants and the nine-input median network for the 3x3 median filter.
// Used by the channel interfaces, the top level and the checker; depends on nothing.
package mf3_pkg;

	// Pixel data.
	localparam int PIX_W = 8;
	typedef logic [PIX_W-1:0] pix_t;

	// Configuration port geometry and register indexes.
	localparam int CFG_DATA_W = 16;
	localparam int REG_IDX_W  = 1;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 16;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// Register reset values and legal minimum size.
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
	localparam int MIN_SIZE = 3;

	// Geometry of the filter.
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int WINDOW_SIZE   = 3;
	localparam int TAPS          = WINDOW_SIZE * WINDOW_SIZE;
	localparam int CENTRE_LAG    = 2;
	localparam pix_t BORDER_VALUE = 8'd255;

	// Orders two values so that a holds the smaller one.
	function automatic void cmp_swap(inout pix_t a, inout pix_t b);
		pix_t lo;
		pix_t hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		a = lo;
		b = hi;
	endfunction

	// Fifth smallest of nine values through a fixed 19-exchange network.
	function automatic pix_t median9(input pix_t t [TAPS]);
		pix_t p [TAPS];
		p = t;
		cmp_swap(p[1], p[2]);
		cmp_swap(p[4], p[5]);
		cmp_swap(p[7], p[8]);
		cmp_swap(p[0], p[1]);
		cmp_swap(p[3], p[4]);
		cmp_swap(p[6], p[7]);
		cmp_swap(p[1], p[2]);
		cmp_swap(p[4], p[5]);
		cmp_swap(p[7], p[8]);
		cmp_swap(p[0], p[3]);
		cmp_swap(p[5], p[8]);
		cmp_swap(p[4], p[7]);
		cmp_swap(p[3], p[6]);
		cmp_swap(p[1], p[4]);
		cmp_swap(p[2], p[5]);
		cmp_swap(p[4], p[7]);
		cmp_swap(p[4], p[2]);
		cmp_swap(p[6], p[4]);
		cmp_swap(p[4], p[2]);
		return p[4];
	endfunction

endpackage

// ===== rtl/mf3_if.sv =====
// Valid/ready stream interfaces for the pixel input and the filtered pixel output.
// Depends on mf3_pkg for the pixel type.

interface mf3_in_if;
	logic           valid;
	logic           ready;
	mf3_pkg::pix_t  pixel_in;

	modport source(output valid, output pixel_in, input ready);
	modport sink(input valid, input pixel_in, output ready);
endinterface

interface mf3_out_if;
	logic           valid;
	logic           ready;
	mf3_pkg::pix_t  pixel_out;
	logic           frame_start;

	modport source(output valid, output pixel_out, output frame_start, input ready);
	modport sink(input valid, input pixel_out, input frame_start, output ready);
endinterface

// ===== rtl/median_filter_3x3.sv =====
// Streaming 3x3 median filter for 8-bit grey frames, top level.
// Depends on mf3_pkg and the mf3_in_if / mf3_out_if stream interfaces.
//
// One pixel is taken per clock in raster order and one filtered pixel is returned for
// each, the window centre that lies image_width+1 pixels earlier in the stream. Interior
// positions get the median of the nine neighbors, the one-pixel frame border and
// everything before the first frame get 255, and frame_start marks row 0, column 0.
// The block sustains one transfer per clock in both directions while the output is not
// stalled and no clearing pass runs. A pixel passes from the stage 1 input register to
// the output register, from which its result transfers out; a stalled output holds the
// next pixel in the input register and drops the input ready in the same cycle. The two
// line stores are memories of MAX_WIDTH entries with one read and one write port, read
// at the input transfer and written when that pixel moves on to the output register.
// After reset a clearing pass zeroes all MAX_WIDTH entries (1024 by default), during
// which no pixel is taken; configuration writes are taken at any time. Sizes outside
// the legal range are clamped: width to 3..MAX_WIDTH, height to at least 3.
module median_filter_3x3 #(
	parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mf3_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data,
	mf3_in_if.sink                         pix_in,
	mf3_out_if.source                      pix_out
);

	// Column index width, and a compare width that holds both the register and MAX_WIDTH.
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int MW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (mf3_pkg::WIDTH_W > MW) ? mf3_pkg::WIDTH_W : MW;
	localparam int HW = mf3_pkg::HEIGHT_W;
	localparam int WIN_DEPTH = 2 * mf3_pkg::WINDOW_SIZE;

	// Configuration registers.
	logic [mf3_pkg::WIDTH_W-1:0] image_width_q;
	logic [HW-1:0]               image_height_q;

	// Raster position of the next pixel.
	logic [CW-1:0] col_q;
	logic [HW-1:0] row_q;

	// Line store clearing after reset.
	logic          clr_busy_q;
	logic [CW-1:0] clr_addr_q;

	// Line stores.
	mf3_pkg::pix_t upper_mem [MAX_WIDTH];
	mf3_pkg::pix_t lower_mem [MAX_WIDTH];

	// Stage 1: accepted pixel, line store read data and position flags.
	logic          s1_valid_q;
	mf3_pkg::pix_t px_s1;
	mf3_pkg::pix_t top_s1;
	mf3_pkg::pix_t mid_s1;
	logic [CW-1:0] col_s1;
	logic          interior_s1;
	logic          start_s1;

	// Two earlier columns of the window.
	mf3_pkg::pix_t win_q [WIN_DEPTH];

	// Stage 2: output register.
	logic          s2_valid_q;
	mf3_pkg::pix_t pixel_out_s2;
	logic          frame_start_s2;

	// Handshake and combinational position logic.
	logic          in_xfer;
	logic          s1_adv;
	logic [EW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic          col_wrap;
	logic [HW:0]   row_pre;
	logic [CW-1:0] cur_col;
	logic [HW-1:0] cur_row;
	logic [EW-1:0] col_inc;
	logic [HW:0]   row_inc;
	logic [CW-1:0] col_nxt;
	logic [HW-1:0] row_nxt;
	logic          mem_we;
	logic [CW-1:0] mem_addr;
	mf3_pkg::pix_t mem_wd_upper;
	mf3_pkg::pix_t mem_wd_lower;
	mf3_pkg::pix_t taps [mf3_pkg::TAPS];
	mf3_pkg::pix_t med;

	// Stage 1 moves on when the output register is empty or being emptied.
	assign s1_adv       = s1_valid_q && (!s2_valid_q || pix_out.ready);
	assign pix_in.ready = !clr_busy_q && (!s1_valid_q || s1_adv);
	assign in_xfer      = pix_in.valid && pix_in.ready;

	assign pix_out.valid       = s2_valid_q;
	assign pix_out.pixel_out   = pixel_out_s2;
	assign pix_out.frame_start = frame_start_s2;

	// Effective frame size after clamping.
	always_comb begin
		if (image_width_q < mf3_pkg::WIDTH_W'(mf3_pkg::MIN_SIZE)) begin
			eff_w = EW'(mf3_pkg::MIN_SIZE);
		end else if (EW'(image_width_q) > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(image_width_q);
		end
		if (image_height_q < HW'(mf3_pkg::MIN_SIZE)) begin
			eff_h = HW'(mf3_pkg::MIN_SIZE);
		end else begin
			eff_h = image_height_q;
		end
	end

	// Position of the incoming pixel, wrapped if the size shrank, and the next position.
	always_comb begin
		col_wrap = EW'(col_q) >= eff_w;
		cur_col  = col_wrap ? '0 : col_q;
		row_pre  = col_wrap ? ({1'b0, row_q} + 1'b1) : {1'b0, row_q};
		cur_row  = (row_pre >= {1'b0, eff_h}) ? '0 : row_pre[HW-1:0];
		col_inc  = EW'(cur_col) + 1'b1;
		row_inc  = {1'b0, cur_row} + 1'b1;
		if (col_inc >= eff_w) begin
			col_nxt = '0;
			row_nxt = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[HW-1:0];
		end else begin
			col_nxt = col_inc[CW-1:0];
			row_nxt = cur_row;
		end
	end

	// The line store write port clears after reset, then takes the shifted column.
	always_comb begin
		mem_we       = clr_busy_q || s1_adv;
		mem_addr     = clr_busy_q ? clr_addr_q : col_s1;
		mem_wd_upper = clr_busy_q ? '0 : mid_s1;
		mem_wd_lower = clr_busy_q ? '0 : px_s1;
	end

	// Window taps and the median selection.
	always_comb begin
		for (int k = 0; k < WIN_DEPTH; k++) begin
			taps[k] = win_q[k];
		end
		taps[WIN_DEPTH]     = top_s1;
		taps[WIN_DEPTH + 1] = mid_s1;
		taps[WIN_DEPTH + 2] = px_s1;
		med = mf3_pkg::median9(taps);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= mf3_pkg::WIDTH_RESET;
			image_height_q <= mf3_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mf3_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[mf3_pkg::WIDTH_W-1:0];
				end
				mf3_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[HW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clearing pass, position counters and pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (in_xfer) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
			if (in_xfer) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	// Line stores: at most one write and one registered read per clock.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			upper_mem[mem_addr] <= mem_wd_upper;
			lower_mem[mem_addr] <= mem_wd_lower;
		end
		if (in_xfer) begin
			top_s1 <= upper_mem[cur_col];
			mid_s1 <= lower_mem[cur_col];
		end
	end

	// Stage 1 payload; frame start is row 1, column 1 of the incoming pixel.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			px_s1       <= pix_in.pixel_in;
			col_s1      <= cur_col;
			interior_s1 <= (cur_row >= HW'(mf3_pkg::CENTRE_LAG)) &&
				(cur_col >= CW'(mf3_pkg::CENTRE_LAG));
			start_s1    <= (cur_row == HW'(1)) && (cur_col == CW'(1));
		end
	end

	// Window shift and output register, once per pixel as it leaves stage 1.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int k = 0; k < mf3_pkg::WINDOW_SIZE; k++) begin
				win_q[k] <= win_q[k + mf3_pkg::WINDOW_SIZE];
			end
			win_q[mf3_pkg::WINDOW_SIZE]     <= top_s1;
			win_q[mf3_pkg::WINDOW_SIZE + 1] <= mid_s1;
			win_q[mf3_pkg::WINDOW_SIZE + 2] <= px_s1;
			pixel_out_s2   <= interior_s1 ? med : mf3_pkg::BORDER_VALUE;
			frame_start_s2 <= start_s1;
		end
	end

endmodule

// ===== rtl/mf3_checker.sv =====
// Port-level checker for the 3x3 median filter, bound to the top level.
// Depends on mf3_pkg and the macros in median_filter_3x3_assert.svh.
`include "median_filter_3x3_assert.svh"

module mf3_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input mf3_pkg::pix_t pixel_out,
	input logic          frame_start
);

	// A stalled result stays offered and unchanged.
	`MF3_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(frame_start), "stalled output changed")

	// The first pixel of a frame sits on the border.
	`MF3_ASSERT_NOW(a_start_border, clk, arst_n, out_valid && frame_start, pixel_out == mf3_pkg::BORDER_VALUE, "frame start pixel is not border value")

	// A result appears from empty only after an input transfer has passed through stage 1 into the output register.
	`MF3_ASSERT_NOW(a_out_from_in, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "output without matching input transfer")

	// The line stores are being cleared right after reset, so no pixel is taken.
	`MF3_ASSERT_NEXT(a_clear_after_reset, clk, arst_n, $rose(arst_n), !in_ready, "input taken during line store clear")

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pix_in.valid),
	.in_ready    (pix_in.ready),
	.out_valid   (pix_out.valid),
	.out_ready   (pix_out.ready),
	.pixel_out   (pix_out.pixel_out),
	.frame_start (pix_out.frame_start)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the streaming 3x3 median filter, median_filter_3x3.
// Depends on mf3_pkg and the mf3_in_if / mf3_out_if stream interfaces from the RTL.
// A scoreboard class predicts every filtered pixel and checks each output transfer in order.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mf3_pkg::*;

	localparam int CLK_PERIOD  = 12;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 8;
	localparam int NUM_PHASES  = 7;

	// One filtered pixel as it leaves the block.
	typedef struct packed {
		pix_t pixel;
		logic frame_start;
	} filtered_t;

	// Predicts the filter output from the accepted pixels and the register writes.
	class median_scoreboard;
		logic [WIDTH_W-1:0]  width_reg;
		logic [HEIGHT_W-1:0] height_reg;
		pix_t                row_two_up [MAX_WIDTH_DEF];
		pix_t                row_one_up [MAX_WIDTH_DEF];
		pix_t                window [2*WINDOW_SIZE];
		int unsigned         col;
		int unsigned         row;
		filtered_t           awaited_q [$];
		int unsigned         mismatches;
		int unsigned         pixels_taken;
		int unsigned         pixels_checked;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (row_two_up[i]) row_two_up[i] = '0;
			foreach (row_one_up[i]) row_one_up[i] = '0;
			foreach (window[i]) window[i] = '0;
			col = 0;
			row = 0;
			mismatches = 0;
			pixels_taken = 0;
			pixels_checked = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_IMAGE_WIDTH) begin
				width_reg = data[WIDTH_W-1:0];
			end else if (idx == REG_IMAGE_HEIGHT) begin
				height_reg = data[HEIGHT_W-1:0];
			end
		endfunction

		// The fifth smallest value is the one with at most four strictly below it
		// and at least five at or below it.
		function pix_t fifth_of_nine(pix_t v [TAPS]);
			int below;
			int at_or_below;
			for (int i = 0; i < TAPS; i++) begin
				below = 0;
				at_or_below = 0;
				for (int j = 0; j < TAPS; j++) begin
					if (v[j] < v[i]) below++;
					if (v[j] <= v[i]) at_or_below++;
				end
				if (below <= TAPS / 2 && at_or_below > TAPS / 2) return v[i];
			end
			return BORDER_VALUE;
		endfunction

		function int unsigned pending();
			return awaited_q.size();
		endfunction

		// Advances the raster position by one pixel and queues the window centre result.
		function void note_pixel(pix_t px);
			int unsigned w;
			int unsigned h;
			pix_t        top;
			pix_t        mid;
			pix_t        taps [TAPS];
			filtered_t   res;

			w = (width_reg < MIN_SIZE) ? MIN_SIZE :
				(width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
			h = (height_reg < MIN_SIZE) ? MIN_SIZE : height_reg;

			// A smaller size written mid-frame wraps the position before the pixel lands.
			if (col >= w) begin
				col = 0;
				row++;
			end
			if (row >= h) row = 0;

			top = row_two_up[col];
			mid = row_one_up[col];
			res.pixel = BORDER_VALUE;
			res.frame_start = (row == 1 && col == 1);
			if (row >= CENTRE_LAG && col >= CENTRE_LAG) begin
				for (int k = 0; k < 2*WINDOW_SIZE; k++) taps[k] = window[k];
				taps[6] = top;
				taps[7] = mid;
				taps[8] = px;
				res.pixel = fifth_of_nine(taps);
			end

			// Shift the line stores and the window by one column.
			row_two_up[col] = mid;
			row_one_up[col] = px;
			for (int k = 0; k < WINDOW_SIZE; k++) window[k] = window[k+WINDOW_SIZE];
			window[3] = top;
			window[4] = mid;
			window[5] = px;

			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col++;
			end
			awaited_q.insert(awaited_q.size(), res);
			pixels_taken++;
		endfunction

		task report_mismatch(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			mismatches++;
		endtask

		// Compares one output transfer with the oldest prediction.
		task check_result(pix_t pixel, logic frame_start);
			filtered_t exp_res;
			if (awaited_q.size() == 0) begin
				report_mismatch($sformatf("unexpected output pixel %0d frame_start %b",
					pixel, frame_start));
			end else begin
				exp_res = awaited_q.pop_front();
				pixels_checked++;
				if (pixel !== exp_res.pixel)
					report_mismatch($sformatf("output %0d: pixel_out %0d, predicted %0d",
						pixels_checked, pixel, exp_res.pixel));
				if (frame_start !== exp_res.frame_start)
					report_mismatch($sformatf("output %0d: frame_start %b, predicted %b",
						pixels_checked, frame_start, exp_res.frame_start));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mf3_in_if  in_ch();
	mf3_out_if out_ch();

	median_scoreboard sb;
	int unsigned      snd_idle_pct;
	int unsigned      rcv_stall_pct;
	int unsigned      quiet_cycles;
	int unsigned      settings_run;
	pix_t             last_pixel;

	median_filter_3x3 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (in_ch),
		.pix_out   (out_ch)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// Output side back-pressure.
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
	end

	// Both channels are sampled at the edge on which each transfer happens.
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) sb.note_pixel(in_ch.pixel_in);
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.pixel_out, out_ch.frame_start);
	end

	// Ends the run when no transfer has happened for too long.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Single register write, after which the enable is driven low again.
	task write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one pixel after a random idle gap and waits for its transfer.
	task drive_pixel(input pix_t px);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pixel_in <= px;
		do @(posedge clk); while (!in_ch.ready);
		last_pixel = px;
	endtask

	// Waits until every predicted pixel has come out, and then for a further drain wait.
	task wait_drained();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Random pixels: uniform values, extremes and repeats for ties, and smooth runs.
	function pix_t next_pixel(pix_t prev);
		case ($urandom_range(0, 3))
			0, 1: return pix_t'($urandom);
			2: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return BORDER_VALUE;
					default: return prev;
				endcase
			end
			default: return prev + pix_t'($urandom_range(0, 6)) - pix_t'(3);
		endcase
	endfunction

	task set_idling(input int unsigned mode);
		case (mode % 4)
			0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
			1: begin snd_idle_pct = 76; rcv_stall_pct = 0;  end
			2: begin snd_idle_pct = 0;  rcv_stall_pct = 76; end
			default: begin snd_idle_pct = 17; rcv_stall_pct = 17; end
		endcase
	endtask

	// Writes a new frame size once the block is idle, then streams random pixels.
	task run_setting(input int unsigned w, input int unsigned h, input int unsigned n,
			input int unsigned mode);
		wait_drained();
		write_reg(REG_IMAGE_WIDTH, {5'($urandom), w[WIDTH_W-1:0]});
		write_reg(REG_IMAGE_HEIGHT, h[HEIGHT_W-1:0]);
		settings_run++;
		set_idling(mode);
		for (int i = 0; i < n; i++) drive_pixel(next_pixel(last_pixel));
	endtask

	// Frame sizes: tiny frames, the tallest frame, and the widest rows including
	// clamped values below and above the legal range.
	int unsigned set_w [NUM_PHASES] = '{3, 5, 4, 9, 1024, 2047, 1};
	int unsigned set_h [NUM_PHASES] = '{3, 4, 65535, 7, 40, 2, 65535};
	int unsigned set_n [NUM_PHASES] = '{160, 160, 160, 160, 1040, 60, 70};

	// Directed pixels: field extremes and alternating bit patterns.
	pix_t directed_px [20] = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h55, 8'hAA,
		8'h00, 8'hFF, 8'h10, 8'hEF, 8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h02, 8'hFD, 8'h40, 8'hBF};

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.pixel_in = '0;
		out_ch.ready = 1'b0;
		quiet_cycles = 0;
		settings_run = 0;
		last_pixel = '0;
		set_idling(0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size: everything before the first frame is border without frame_start.
		for (int i = 0; i < 4; i++) drive_pixel(pix_t'(i * 85));

		// Out-of-range sizes clamp to 3x3, and the column wraps since it lies past the new width.
		wait_drained();
		write_reg(REG_IMAGE_WIDTH, 16'd2);
		write_reg(REG_IMAGE_HEIGHT, 16'd0);
		foreach (directed_px[i]) drive_pixel(directed_px[i]);

		// Random phases, each with its own frame size and one of four idling patterns.
		for (int p = 0; p < NUM_PHASES; p++) run_setting(set_w[p], set_h[p], set_n[p], p);

		wait_drained();
		$display("Covered %0d pixels in and %0d filtered pixels out over %0d frame sizes",
			sb.pixels_taken, sb.pixels_checked, settings_run + 1);
		$display("with clamped widths and heights, mid-frame resizes and four idling patterns.");
		if (sb.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mf3_pkg.sv
rtl/mf3_if.sv
rtl/median_filter_3x3.sv
rtl/mf3_checker.sv
tb/sv/tb_top.sv
